### rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/tsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

    localparam int BEAM_COUNT_DEF = 512;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_NOISE_LIMIT  = 1'd0;
    localparam t_cfg_idx CFG_MOUNT_OFFSET = 1'd1;

    localparam logic [14:0] NOISE_LIMIT_RST  = 15'd1100;
    localparam logic [9:0]  MOUNT_OFFSET_RST = 10'd84;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 2;
    localparam int POS_W       = 18;

    // beam index times 180 fits in this many bits
    localparam int BPROD_W = 17;

    // mod 360 by reciprocal multiply, exact for 16-bit inputs
    localparam logic [16:0] MOD_RECIP = 17'd93207;
    localparam int          MOD_SHIFT = 25;

    typedef struct packed {
        logic load_in;
        logic sv_mul;
        logic sv_fold;
        logic bm_mul;
        logic bm_div;
        logic mod_q;
        logic tilt_we;
        logic bdeg_we;
        logic trig;
        logic pair;
        logic rng;
        logic sum;
        logic out_ld;
    } t_dp_cmd;

    typedef struct packed {
        logic is_range;
        logic noise;
    } t_dp_sts;

    localparam logic [14:0] SIN_Q15 [0:90] = '{
        15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,
        15'd2856,  15'd3425,  15'd3993,  15'd4560,  15'd5126,
        15'd5690,  15'd6252,  15'd6813,  15'd7371,  15'd7927,
        15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668,
        15'd11207, 15'd11743, 15'd12275, 15'd12803, 15'd13328,
        15'd13848, 15'd14365, 15'd14876, 15'd15384, 15'd15886,
        15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
        15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622,
        15'd21063, 15'd21498, 15'd21926, 15'd22348, 15'd22763,
        15'd23170, 15'd23571, 15'd23965, 15'd24351, 15'd24730,
        15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510,
        15'd26842, 15'd27166, 15'd27482, 15'd27789, 15'd28088,
        15'd28378, 15'd28660, 15'd28932, 15'd29197, 15'd29452,
        15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
        15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499,
        15'd31651, 15'd31795, 15'd31928, 15'd32052, 15'd32166,
        15'd32270, 15'd32365, 15'd32449, 15'd32524, 15'd32588,
        15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763,
        15'd32767
    };

    // d in 0..359
    function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
        logic [8:0]         r;
        logic               neg;
        logic signed [15:0] v;
        if (d >= 9'd270) begin
            r   = 9'd360 - d;
            neg = 1'b1;
        end else if (d >= 9'd180) begin
            r   = d - 9'd180;
            neg = 1'b1;
        end else if (d >= 9'd90) begin
            r   = 9'd180 - d;
            neg = 1'b0;
        end else begin
            r   = d;
            neg = 1'b0;
        end
        v = $signed({1'b0, SIN_Q15[r[6:0]]});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [15:0] cos_deg(input logic [8:0] d);
        logic [8:0] e;
        e = (d >= 9'd270) ? d - 9'd270 : d + 9'd90;
        return sin_deg(e);
    endfunction

endpackage

`default_nettype wire

### rtl/tilted_scan_to_cartesian.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts range samples from a laser on a tilting mount into x, y, z points in
// 1/1024 m. A servo word (tuser 0) updates the stored tilt, or only raises
// noise_flag when the reading is above noise_limit; a range word (tuser 1)
// yields one point from the stored tilt and the beam angle. Every input word
// gives exactly one output word. Words are handled one at a time by a
// sequencer stepping a single datapath; a range word passes through more
// states than a servo word, a noisy servo word through fewer, and the
// output register waits on m_axis_tready before it loads. The next input word is
// taken while a finished result still waits. Config writes are taken any time
// but should only be issued while the block is idle.

`include "assert_macros.svh"

module tilted_scan_to_cartesian #(
    parameter int BEAM_COUNT = tsc_pkg::BEAM_COUNT_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [tsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [tsc_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // servo_reading, beam_index, range_value, zero pad
    input  wire  [tsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // cmd
    input  wire                                 s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // x_pos, y_pos, z_pos, zero pad
    output logic [tsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // point_valid, noise_flag
    output logic [tsc_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    tsc_pkg::t_dp_cmd w_cmd;
    tsc_pkg::t_dp_sts w_sts;

    logic                              w_point_valid;
    logic                              w_noise_flag;
    logic signed [tsc_pkg::POS_W-1:0]  w_x_pos;
    logic signed [tsc_pkg::POS_W-1:0]  w_y_pos;
    logic signed [tsc_pkg::POS_W-1:0]  w_z_pos;

    tsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tsc_dp #(
        .BEAM_COUNT (BEAM_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_cmd        (s_axis_tuser),
        .i_servo_reading ($signed(s_axis_tdata[15:0])),
        .i_beam_index    (s_axis_tdata[24:16]),
        .i_range_value   (s_axis_tdata[40:25]),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_point_valid   (w_point_valid),
        .o_noise_flag    (w_noise_flag),
        .o_x_pos         (w_x_pos),
        .o_y_pos         (w_y_pos),
        .o_z_pos         (w_z_pos)
    );

    assign m_axis_tdata = {2'b00, w_z_pos, w_y_pos, w_x_pos};
    assign m_axis_tuser = {w_noise_flag, w_point_valid};

    `ASSERT_NEXT(a_one_word_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted while a word is in flight")
    `ASSERT_SAME(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.out_ld, !m_axis_tvalid || m_axis_tready, "pending result overwritten")
    `ASSERT_NEXT(a_result_shown, i_clk, i_rst_n, w_cmd.out_ld, m_axis_tvalid, "loaded result not presented")
    `ASSERT_SAME(a_ready_only_when_idle, i_clk, i_rst_n, s_axis_tready, !(w_cmd.trig || w_cmd.pair || w_cmd.rng || w_cmd.sum || w_cmd.out_ld), "ready while datapath busy")

endmodule

`default_nettype wire

### rtl/tsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire              i_in_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  tsc_pkg::t_dp_sts i_sts,
    output tsc_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SV_MUL,
        S_SV_FOLD,
        S_BM_MUL,
        S_BM_DIV,
        S_MOD_Q,
        S_MOD_R,
        S_TRIG,
        S_PAIR,
        S_RNG,
        S_SUM,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = i_in_cmd ? S_BM_MUL : S_SV_MUL;
                end
            end
            S_SV_MUL: begin
                o_cmd.sv_mul = 1'b1;
                n_state = S_SV_FOLD;
            end
            S_SV_FOLD: begin
                o_cmd.sv_fold = 1'b1;
                n_state = i_sts.noise ? S_OUT : S_MOD_Q;
            end
            S_BM_MUL: begin
                o_cmd.bm_mul = 1'b1;
                n_state = S_BM_DIV;
            end
            S_BM_DIV: begin
                o_cmd.bm_div = 1'b1;
                n_state = S_MOD_Q;
            end
            S_MOD_Q: begin
                o_cmd.mod_q = 1'b1;
                n_state = S_MOD_R;
            end
            S_MOD_R: begin
                o_cmd.tilt_we = !i_sts.is_range;
                o_cmd.bdeg_we = i_sts.is_range;
                n_state = i_sts.is_range ? S_TRIG : S_OUT;
            end
            S_TRIG: begin
                o_cmd.trig = 1'b1;
                n_state = S_PAIR;
            end
            S_PAIR: begin
                o_cmd.pair = 1'b1;
                n_state = S_RNG;
            end
            S_RNG: begin
                o_cmd.rng = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/tsc_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tsc_dp #(
    parameter int BEAM_COUNT = tsc_pkg::BEAM_COUNT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [tsc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire  [tsc_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    input  wire                                  i_in_cmd,
    input  wire  signed [15:0]                   i_servo_reading,
    input  wire  [8:0]                           i_beam_index,
    input  wire  [15:0]                          i_range_value,
    input  tsc_pkg::t_dp_cmd                     i_cmd,
    output tsc_pkg::t_dp_sts                     o_sts,
    output logic                                 o_point_valid,
    output logic                                 o_noise_flag,
    output logic signed [tsc_pkg::POS_W-1:0]     o_x_pos,
    output logic signed [tsc_pkg::POS_W-1:0]     o_y_pos,
    output logic signed [tsc_pkg::POS_W-1:0]     o_z_pos
);

    localparam int BSHIFT   = tsc_pkg::BPROD_W + $clog2(BEAM_COUNT);
    localparam int BRECIP_W = BSHIFT - $clog2(BEAM_COUNT) + 2;
    localparam int BMUL_W   = tsc_pkg::BPROD_W + BRECIP_W;
    localparam logic [BRECIP_W-1:0] BRECIP = BRECIP_W'(
        ((64'd1 << BSHIFT) + 64'(BEAM_COUNT) - 64'd1) / 64'(BEAM_COUNT));

    localparam logic signed [22:0] SV_SCALE  = 23'sd90;
    localparam logic signed [22:0] SV_ROUND  = 23'sd1023;
    localparam logic signed [13:0] TILT_BIAS = 14'sd2880;
    localparam logic [16:0]        BEAM_SCALE = 17'd180;
    localparam logic [15:0]        DEG_FULL   = 16'd360;

    localparam logic signed [tsc_pkg::POS_W-1:0] POS_MAX = {1'b0, {(tsc_pkg::POS_W-1){1'b1}}};
    localparam logic signed [tsc_pkg::POS_W-1:0] POS_MIN = {1'b1, {(tsc_pkg::POS_W-1){1'b0}}};

    function automatic logic signed [tsc_pkg::POS_W-1:0] round_sat(
        input logic signed [47:0] p
    );
        logic [47:0] mag;
        logic [18:0] v;
        logic signed [tsc_pkg::POS_W-1:0] res;
        mag = p[47] ? 48'(-p) : 48'(p);
        v   = 19'((mag + 48'd536870912) >> 30);
        if (!p[47]) begin
            res = (v > 19'd131071) ? POS_MAX : tsc_pkg::POS_W'(v);
        end else begin
            res = (v > 19'd131072) ? POS_MIN : -tsc_pkg::POS_W'(v);
        end
        return res;
    endfunction

    logic [14:0] r_noise_lim;
    logic [9:0]  r_mount_off;
    logic [8:0]  r_tilt;

    logic               r_is_range;
    logic signed [15:0] r_reading;
    logic [8:0]         r_beam;
    logic [15:0]        r_range;

    logic signed [22:0]            r_svp;
    logic                          r_noise;
    logic [tsc_pkg::BPROD_W-1:0]   r_bprod;
    logic [15:0]                   r_u;
    logic [7:0]                    r_q;
    logic [8:0]                    r_bdeg;
    logic signed [15:0]            r_st;
    logic signed [15:0]            r_ct;
    logic signed [15:0]            r_sb;
    logic signed [15:0]            r_cb;
    logic signed [30:0]            r_ax;
    logic signed [30:0]            r_ay;
    logic signed [30:0]            r_az;
    logic signed [26:0]            r_mnt;
    logic signed [46:0]            r_px;
    logic signed [46:0]            r_py;
    logic signed [46:0]            r_pz;
    logic signed [47:0]            r_sx;
    logic signed [47:0]            r_sy;
    logic signed [47:0]            r_sz;

    logic signed [22:0] w_sv_bias;
    logic signed [22:0] w_sv_div;
    logic signed [13:0] w_sv_off;
    logic [8:0]         w_deg;
    logic signed [16:0] w_rng_s;
    logic signed [47:0] w_mnt_sc;

    assign w_sv_bias = r_svp + (r_svp[22] ? SV_ROUND : 23'sd0);
    assign w_sv_div  = w_sv_bias >>> 10;
    assign w_sv_off  = 14'(w_sv_div) + TILT_BIAS;
    assign w_deg     = 9'(r_u - 16'(16'(r_q) * DEG_FULL));
    assign w_rng_s   = $signed({1'b0, r_range});
    assign w_mnt_sc  = 48'(r_mnt) <<< 15;

    assign o_sts.is_range = r_is_range;
    assign o_sts.noise    = r_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_lim <= tsc_pkg::NOISE_LIMIT_RST;
            r_mount_off <= tsc_pkg::MOUNT_OFFSET_RST;
            r_tilt      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tsc_pkg::CFG_NOISE_LIMIT:  r_noise_lim <= i_cfg_wdata;
                    tsc_pkg::CFG_MOUNT_OFFSET: r_mount_off <= i_cfg_wdata[9:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tilt_we) begin
                r_tilt <= w_deg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_range <= i_in_cmd;
            r_reading  <= i_servo_reading;
            r_beam     <= i_beam_index;
            r_range    <= i_range_value;
        end
        if (i_cmd.sv_mul) begin
            r_svp   <= 23'(r_reading) * SV_SCALE;
            r_noise <= r_reading > $signed({1'b0, r_noise_lim});
        end
        if (i_cmd.sv_fold) begin
            r_u <= {2'b00, w_sv_off};
        end
        if (i_cmd.bm_mul) begin
            r_noise <= 1'b0;
            r_bprod <= tsc_pkg::BPROD_W'(r_beam) * BEAM_SCALE;
        end
        if (i_cmd.bm_div) begin
            r_u <= 16'((BMUL_W'(r_bprod) * BMUL_W'(BRECIP)) >> BSHIFT);
        end
        if (i_cmd.mod_q) begin
            r_q <= 8'((33'(r_u) * 33'(tsc_pkg::MOD_RECIP)) >> tsc_pkg::MOD_SHIFT);
        end
        if (i_cmd.bdeg_we) begin
            r_bdeg <= w_deg;
        end
        if (i_cmd.trig) begin
            r_st <= tsc_pkg::sin_deg(r_tilt);
            r_ct <= tsc_pkg::cos_deg(r_tilt);
            r_sb <= tsc_pkg::sin_deg(r_bdeg);
            r_cb <= tsc_pkg::cos_deg(r_bdeg);
        end
        if (i_cmd.pair) begin
            r_ax  <= 31'(r_st) * 31'(r_cb);
            r_ay  <= 31'(r_st) * 31'(r_sb);
            r_az  <= 31'(r_ct) * 31'(r_sb);
            r_mnt <= 27'($signed({1'b0, r_mount_off})) * 27'(r_ct);
        end
        if (i_cmd.rng) begin
            r_px <= 47'(r_ax) * 47'(w_rng_s);
            r_py <= 47'(r_ay) * 47'(w_rng_s);
            r_pz <= 47'(r_az) * 47'(w_rng_s);
        end
        if (i_cmd.sum) begin
            r_sx <= 48'(r_px);
            r_sy <= 48'(r_py) + w_mnt_sc;
            r_sz <= w_mnt_sc - 48'(r_pz);
        end
        if (i_cmd.out_ld) begin
            if (r_is_range) begin
                o_point_valid <= 1'b1;
                o_noise_flag  <= 1'b0;
                o_x_pos       <= round_sat(r_sx);
                o_y_pos       <= round_sat(r_sy);
                o_z_pos       <= round_sat(r_sz);
            end else begin
                o_point_valid <= 1'b0;
                o_noise_flag  <= r_noise;
                o_x_pos       <= '0;
                o_y_pos       <= '0;
                o_z_pos       <= '0;
            end
        end
    end

endmodule

`default_nettype wire
